// ===== hdl/cid_pkg.sv =====
// shared types and constants for the cascaded interrupt dispatcher
package cid_pkg;

    localparam int VECTOR_COUNT = 32;

    localparam int OP_W   = 3;
    localparam int VN_W   = 6;
    localparam int VEC_W  = 5;
    localparam int GRP_W  = 7;
    localparam int BYTE_W = 8;
    localparam int LVL_W  = 3;

    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd0;
    localparam logic [OP_W-1:0] OP_DISABLE = 3'd1;
    localparam logic [OP_W-1:0] OP_CAUSE   = 3'd2;
    localparam logic [OP_W-1:0] OP_SOFT    = 3'd3;
    localparam logic [OP_W-1:0] OP_SERVICE = 3'd4;

    // vector number bits [4:3] select the bank
    localparam logic [1:0] BANK_TOP   = 2'd0;
    localparam logic [1:0] BANK_GRP1  = 2'd1;
    localparam logic [1:0] BANK_GRP2  = 2'd2;
    localparam logic [1:0] BANK_SLOTS = 2'd3;

    localparam logic [BYTE_W-1:0] TOP_ENABLE_RESET = 8'h06;
    localparam logic [BYTE_W-1:0] TOP_ENABLE_KEEP  = 8'h06;
    localparam logic [GRP_W-1:0]  GRP2_CASCADE     = 7'h02;
    localparam logic [GRP_W-1:0]  GRP2_NO_CASCADE  = 7'h7D;
    localparam logic [GRP_W-1:0]  GRP1_DONE_BIT    = 7'h04;

    localparam logic [LVL_W-1:0] LEVEL_GRP1 = 3'd1;
    localparam logic [LVL_W-1:0] LEVEL_GRP2 = 3'd2;

    // job handed from the setup logic to the scan sequencer
    typedef struct packed {
        logic             go;
        logic             blank;
        logic [GRP_W-1:0] clr1;
        logic [GRP_W-1:0] clr2;
        logic             done;
    } t_round;

endpackage

// ===== hdl/cid_ctrl.sv =====
// enable masks, software-pending word and per-transaction round setup
module cid_ctrl #(
    parameter int VECTOR_COUNT = cid_pkg::VECTOR_COUNT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [cid_pkg::OP_W-1:0]     i_opcode,
    input  logic [cid_pkg::VN_W-1:0]     i_vector_number,
    input  logic [cid_pkg::BYTE_W-1:0]   i_icr_status,
    input  logic [cid_pkg::LVL_W-1:0]    i_icr_level,
    input  logic [cid_pkg::BYTE_W-1:0]   i_via1_flags,
    input  logic [cid_pkg::BYTE_W-1:0]   i_via2_flags,
    input  logic [cid_pkg::BYTE_W-1:0]   i_slot_lines,
    output cid_pkg::t_round              o_round,
    output logic [VECTOR_COUNT-1:0]      o_mask
);

    localparam int GW = cid_pkg::GRP_W;
    localparam int BW = cid_pkg::BYTE_W;
    localparam int VC_W = $clog2(VECTOR_COUNT) + 2;

    logic [BW-1:0]           r_top_en, n_top_en;
    logic [GW-1:0]           r_g1_en, n_g1_en;
    logic [GW-1:0]           r_g2_en, n_g2_en;
    logic [BW-1:0]           r_slot_en, n_slot_en;
    logic [VECTOR_COUNT-1:0] r_pend, n_pend;

    logic                    vn_ok;
    logic [BW-1:0]           bit_sel;
    logic [VECTOR_COUNT-1:0] en_all;
    logic [VECTOR_COUNT-1:0] soft_m;
    logic [cid_pkg::LVL_W-1:0] lvl;
    logic [GW-1:0]           g1_ifr, g2_ifr;
    logic [BW-1:0]           slot_req;
    logic [BW-1:0]           slot_emit;
    logic [VECTOR_COUNT-1:0] svc_m;
    logic [BW-1:0]           slot_left;

    assign vn_ok    = VC_W'(i_vector_number) < VC_W'(VECTOR_COUNT);
    assign bit_sel  = BW'(1) << i_vector_number[2:0];
    assign en_all   = VECTOR_COUNT'({r_slot_en, 1'b0, r_g2_en, 1'b0, r_g1_en, r_top_en});
    assign soft_m   = r_pend & en_all;
    assign lvl      = (i_icr_level != '0) ? i_icr_level : i_icr_status[2:0];
    assign g1_ifr   = i_via1_flags[GW-1:0] & r_g1_en;
    assign g2_ifr   = i_via2_flags[GW-1:0] & r_g2_en;
    assign slot_req = ~i_slot_lines & r_slot_en;
    assign slot_emit = ((g2_ifr & cid_pkg::GRP2_CASCADE) != '0) ? slot_req : '0;
    assign slot_left = r_slot_en & ~bit_sel;

    // service round and soft dispatch: emission mask and the constant fields of the round
    always_comb begin
        svc_m          = '0;
        o_round.clr1   = '0;
        o_round.clr2   = '0;
        o_round.done   = 1'b0;
        if (i_icr_status == '0) begin
            o_round.done = 1'b1;
        end else if (lvl == cid_pkg::LEVEL_GRP2) begin
            svc_m        = VECTOR_COUNT'({slot_emit, 1'b0,
                                          g2_ifr & cid_pkg::GRP2_NO_CASCADE, 16'h0000});
            o_round.clr2 = g2_ifr;
        end else if (lvl == cid_pkg::LEVEL_GRP1) begin
            svc_m        = VECTOR_COUNT'({1'b0, g1_ifr, 8'h00});
            o_round.clr1 = g1_ifr;
            o_round.done = (g1_ifr & cid_pkg::GRP1_DONE_BIT) != '0;
        end else begin
            // other top levels go out without a top enable check
            svc_m = VECTOR_COUNT'(1) << lvl;
        end
        if (i_opcode == cid_pkg::OP_SOFT) begin
            o_mask         = soft_m;
            o_round.clr1   = '0;
            o_round.clr2   = '0;
            o_round.done   = 1'b0;
        end else begin
            o_mask = svc_m;
        end
        o_round.go    = i_accept && ((i_opcode == cid_pkg::OP_SERVICE) ||
                                     (i_opcode == cid_pkg::OP_SOFT && soft_m != '0));
        o_round.blank = (i_opcode == cid_pkg::OP_SERVICE) && (svc_m == '0);
    end

    always_comb begin
        n_top_en  = r_top_en;
        n_g1_en   = r_g1_en;
        n_g2_en   = r_g2_en;
        n_slot_en = r_slot_en;
        n_pend    = r_pend;
        if (i_accept) begin
            if (i_opcode == cid_pkg::OP_SOFT) begin
                n_pend = r_pend & ~soft_m;
            end else if (vn_ok && i_opcode == cid_pkg::OP_CAUSE) begin
                n_pend = r_pend | (VECTOR_COUNT'(1) << i_vector_number);
            end else if (vn_ok && (i_opcode == cid_pkg::OP_ENABLE ||
                                   i_opcode == cid_pkg::OP_DISABLE)) begin
                unique case (i_vector_number[4:3])
                    cid_pkg::BANK_TOP: begin
                        if (i_opcode == cid_pkg::OP_ENABLE) n_top_en = r_top_en | bit_sel;
                        else n_top_en = (r_top_en & ~bit_sel) | cid_pkg::TOP_ENABLE_KEEP;
                    end
                    cid_pkg::BANK_GRP1: begin
                        if (i_opcode == cid_pkg::OP_ENABLE) n_g1_en = r_g1_en | bit_sel[GW-1:0];
                        else n_g1_en = r_g1_en & ~bit_sel[GW-1:0];
                    end
                    cid_pkg::BANK_GRP2: begin
                        if (i_opcode == cid_pkg::OP_ENABLE) n_g2_en = r_g2_en | bit_sel[GW-1:0];
                        else n_g2_en = r_g2_en & ~bit_sel[GW-1:0];
                    end
                    cid_pkg::BANK_SLOTS: begin
                        // slot enables drive the cascade bit in the second group
                        if (i_opcode == cid_pkg::OP_ENABLE) begin
                            n_slot_en = r_slot_en | bit_sel;
                            n_g2_en   = r_g2_en | cid_pkg::GRP2_CASCADE;
                        end else begin
                            n_slot_en = slot_left;
                            if (slot_left == '0) n_g2_en = r_g2_en & cid_pkg::GRP2_NO_CASCADE;
                        end
                    end
                    default: begin
                        n_top_en = r_top_en;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_en  <= cid_pkg::TOP_ENABLE_RESET;
            r_g1_en   <= '0;
            r_g2_en   <= '0;
            r_slot_en <= '0;
            r_pend    <= '0;
        end else begin
            r_top_en  <= n_top_en;
            r_g1_en   <= n_g1_en;
            r_g2_en   <= n_g2_en;
            r_slot_en <= n_slot_en;
            r_pend    <= n_pend;
        end
    end

endmodule

// ===== hdl/cid_scan.sv =====
// scan sequencer: shared priority encoder, one vector per cycle to output reg unless stalled
module cid_scan #(
    parameter int VECTOR_COUNT = cid_pkg::VECTOR_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cid_pkg::t_round               i_round,
    input  logic [VECTOR_COUNT-1:0]       i_mask,
    input  logic                          i_stall,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic [cid_pkg::VEC_W-1:0]     o_vector,
    output logic                          o_vector_valid,
    output logic [cid_pkg::GRP_W-1:0]     o_via1_flags_clear,
    output logic [cid_pkg::GRP_W-1:0]     o_via2_flags_clear,
    output logic                          o_round_done,
    output logic                          o_last
);

    localparam int IDX_W = $clog2(VECTOR_COUNT);
    localparam int VW    = cid_pkg::VEC_W;

    logic                    r_busy;
    logic [VECTOR_COUNT-1:0] r_mask, n_mask;
    cid_pkg::t_round         r_round;
    logic                    r_out_valid;
    logic [VW-1:0]           r_vector;
    logic                    r_vector_valid;
    logic [cid_pkg::GRP_W-1:0] r_clr1, r_clr2;
    logic                    r_done;
    logic                    r_last;

    logic                    emit;
    logic [IDX_W-1:0]        idx;
    logic                    fin;

    // highest set bit by halving the window, one index bit per step
    always_comb begin
        logic [VECTOR_COUNT-1:0] w;
        logic [VECTOR_COUNT-1:0] hi;
        w   = r_mask;
        idx = '0;
        for (int s = IDX_W - 1; s >= 0; s--) begin
            hi = w >> (1 << s);
            if (hi != '0) begin
                idx[s] = 1'b1;
                w      = hi;
            end
        end
    end

    assign emit   = r_busy && (!r_out_valid || !i_stall);
    assign n_mask = r_mask & ~(VECTOR_COUNT'(1) << idx);
    assign fin    = r_round.blank || (n_mask == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_round.go) begin
                r_busy <= 1'b1;
            end else if (emit && fin) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_round.go) begin
            r_mask  <= i_mask;
            r_round <= i_round;
        end else if (emit) begin
            r_mask <= n_mask;
        end
        if (emit) begin
            r_vector       <= r_round.blank ? '0 : VW'(idx);
            r_vector_valid <= !r_round.blank;
            r_clr1         <= r_round.clr1;
            r_clr2         <= r_round.clr2;
            r_done         <= r_round.done;
            r_last         <= fin;
        end
    end

    assign o_busy             = r_busy;
    assign o_valid            = r_out_valid;
    assign o_vector           = r_vector;
    assign o_vector_valid     = r_vector_valid;
    assign o_via1_flags_clear = r_clr1;
    assign o_via2_flags_clear = r_clr2;
    assign o_round_done       = r_done;
    assign o_last             = r_last;

endmodule

// ===== hdl/cascaded_interrupt_dispatcher.sv =====
// top level of the cascaded interrupt dispatcher
// Enable, disable and cause transactions give no result. Soft dispatch and service round
// are set up in the cycle the transaction is accepted; after that the shared priority
// encoder emits one result per cycle while the output side does not stall, highest vector
// first. An item gives up to 30 results for soft dispatch, 14 for a service round and one
// for a round with nothing to dispatch. The input is stalled while the encoder is scanning;
// the next item is taken as soon as the final result sits in the output register.
module cascaded_interrupt_dispatcher #(
    parameter int VECTOR_COUNT = cid_pkg::VECTOR_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cid_pkg::OP_W-1:0]      i_opcode,
    input  logic [cid_pkg::VN_W-1:0]      i_vector_number,
    input  logic [cid_pkg::BYTE_W-1:0]    i_icr_status,
    input  logic [cid_pkg::LVL_W-1:0]     i_icr_level,
    input  logic [cid_pkg::BYTE_W-1:0]    i_via1_flags,
    input  logic [cid_pkg::BYTE_W-1:0]    i_via2_flags,
    input  logic [cid_pkg::BYTE_W-1:0]    i_slot_lines,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cid_pkg::VEC_W-1:0]     o_vector,
    output logic                          o_vector_valid,
    output logic [cid_pkg::GRP_W-1:0]     o_via1_flags_clear,
    output logic [cid_pkg::GRP_W-1:0]     o_via2_flags_clear,
    output logic                          o_round_done,
    output logic                          o_last
);

    logic                    busy;
    logic                    accept;
    cid_pkg::t_round         round;
    logic [VECTOR_COUNT-1:0] mask;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    cid_ctrl #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_opcode        (i_opcode),
        .i_vector_number (i_vector_number),
        .i_icr_status    (i_icr_status),
        .i_icr_level     (i_icr_level),
        .i_via1_flags    (i_via1_flags),
        .i_via2_flags    (i_via2_flags),
        .i_slot_lines    (i_slot_lines),
        .o_round         (round),
        .o_mask          (mask)
    );

    cid_scan #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_scan (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_round            (round),
        .i_mask             (mask),
        .i_stall            (i_stall),
        .o_busy             (busy),
        .o_valid            (o_valid),
        .o_vector           (o_vector),
        .o_vector_valid     (o_vector_valid),
        .o_via1_flags_clear (o_via1_flags_clear),
        .o_via2_flags_clear (o_via2_flags_clear),
        .o_round_done       (o_round_done),
        .o_last             (o_last)
    );

    // a result without a vector is always the only one of its transaction
    a_blank_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_vector_valid |-> o_last)
        else $error("blank result not marked last");

    // once a result leaves and more follow, the next one is ready right away
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid)
        else $error("gap inside a multi-result transaction");

    // group bit 7 vectors have no enable and never go out
    a_no_bit7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_vector_valid |-> (o_vector != 5'd15) && (o_vector != 5'd23))
        else $error("unmapped group vector dispatched");

    // a round that ends servicing with a vector can only come from the first group
    a_done_grp1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_vector_valid && o_round_done |-> o_vector[4:3] == cid_pkg::BANK_GRP1)
        else $error("round done with a vector outside the first group");

endmodule
